[design/podi_pkg.sv]
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared beat types, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package podi_pkg;

    // Default values for the top-level parameters.
    localparam int POS_BITS_DEF      = 48;
    localparam int ANGLE_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 16;

    // Output field widths are fixed by the interface.
    localparam int OUT_POS_W = 48;
    localparam int HEAD_W    = 32;

    // The rotator carries Q30 values with headroom for the CORDIC gain.
    localparam int CORDIC_W = 34;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 64;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Position products carry 2^-48 m; results carry 2^-18 m.
    localparam int                      ROUND_SHIFT = 30;
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = 64'sd536870912;

    // Yaw rate times elapsed time carries 2^-26 turn.
    localparam int DTH_FRAC = 26;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic        [15:0] elapsed;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_POS_W-1:0] pose_x;
        logic signed [OUT_POS_W-1:0] pose_y;
        logic        [HEAD_W-1:0]    pose_heading;
    } out_beat_t;

    // Arctangent of 2^-i as a binary angle, full turn equals 2^32.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

[design/podi_cordic.sv]
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Produces cos and sin in Q30 of a 32-bit binary angle, one stage per cycle.
// ----------------------------------------------------------------------------
module podi_cordic #(
    parameter int STAGES = podi_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [31:0]                          angle,
    output logic                                 done,
    output logic signed [podi_pkg::CORDIC_W-1:0] cos_q30,
    output logic signed [podi_pkg::CORDIC_W-1:0] sin_q30
);
    import podi_pkg::*;

    localparam int CNT_W = $clog2(STAGES + 1);

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic                       flip_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [31:0]                quarter;
    logic                       flip;
    logic [31:0]                ang_adj;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] y_shift;
    logic signed [CORDIC_W-1:0] x_shift;
    logic signed [CORDIC_W-1:0] atan_val;
    logic                       last_stage;

    // Angles in the left half-plane are rotated by half a turn and the
    // result is negated at the end, keeping z inside the convergence range.
    always_comb begin
        quarter  = angle + 32'h4000_0000;
        flip     = quarter[31];
        ang_adj  = flip ? (angle + 32'h8000_0000) : angle;
        z_init   = CORDIC_W'($signed(ang_adj));
        y_shift  = y_reg >>> cnt_reg;
        x_shift  = x_reg >>> cnt_reg;
        atan_val = CORDIC_W'(atan_turn(5'(cnt_reg)));
        last_stage = (cnt_reg == CNT_W'(STAGES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (last_stage) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip;
        end else if (busy_reg) begin
            if (last_stage) begin
                if (flip_reg) begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end else if (!z_reg[CORDIC_W-1]) begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    assign done    = done_reg;
    assign cos_q30 = x_reg;
    assign sin_q30 = y_reg;

endmodule

[design/podi_mul.sv]
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed product per cycle, used for every product of an update.
// ----------------------------------------------------------------------------
module podi_mul (
    input  logic                               aclk,
    input  logic signed [podi_pkg::MUL_W-1:0]  mul_a,
    input  logic signed [podi_pkg::MUL_W-1:0]  mul_b,
    output logic signed [podi_pkg::PROD_W-1:0] prod
);
    import podi_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

[design/planar_odometry_integrator_unit.sv]
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning 2-D pose integration from body-frame velocity commands.
// ----------------------------------------------------------------------------
// Each input beat carries a new velocity command and the time since the last
// one. The previously held velocity is rotated by the current heading (an
// iterative CORDIC rotator gives cos and sin), scaled by the elapsed time and
// added to the world position; the heading advances by the held yaw rate times
// the elapsed time, then the new command is latched and the pose goes out as
// one result beat. While an item is worked on, the CORDIC stages run one per
// cycle as the shared multiplier forms the time products, and the four
// rotation products then go through that same multiplier one per cycle.
// s_ready is high only while the block is idle; a finished pose may still
// wait in the output register while the next item is accepted.
module planar_odometry_integrator_unit #(
    parameter int POS_BITS      = podi_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS    = podi_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = podi_pkg::CORDIC_STAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  podi_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output podi_pkg::out_beat_t m_data
);
    import podi_pkg::*;

    localparam int HEAD_SHIFT = HEAD_W - ANGLE_BITS;
    localparam int DTH_SHL    = (ANGLE_BITS >= DTH_FRAC) ? ANGLE_BITS - DTH_FRAC : 0;
    localparam int DTH_SHR    = (ANGLE_BITS >= DTH_FRAC) ? 0 : DTH_FRAC - ANGLE_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MULV  = 6'b000010,
        ST_CWAIT = 6'b000100,
        ST_ROT   = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;

    in_beat_t                   cmd_reg;
    out_beat_t                  m_data_reg;
    logic signed [15:0]         held_vx_reg;
    logic signed [15:0]         held_vy_reg;
    logic signed [15:0]         held_wr_reg;
    logic signed [POS_BITS-1:0] pos_x_reg;
    logic signed [POS_BITS-1:0] pos_y_reg;
    logic [ANGLE_BITS-1:0]      heading_reg;
    logic signed [MUL_W-1:0]    t_reg;
    logic signed [MUL_W-1:0]    u_reg;
    logic signed [MUL_W-1:0]    dth_reg;
    logic signed [ACC_W-1:0]    accx_reg;
    logic signed [ACC_W-1:0]    accy_reg;

    logic                       accept;
    logic                       out_load;
    logic [HEAD_W-1:0]          ang32;
    logic                       cordic_done;
    logic signed [CORDIC_W-1:0] cos_q30;
    logic signed [CORDIC_W-1:0] sin_q30;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [MUL_W-1:0]    el_ext;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod_acc;
    logic signed [MUL_W-1:0]    prod_narrow;
    logic signed [ACC_W-1:0]    round_x;
    logic signed [ACC_W-1:0]    round_y;
    logic signed [ACC_W-1:0]    shift_x;
    logic signed [ACC_W-1:0]    shift_y;
    logic signed [ACC_W-1:0]    dth_wide;
    logic signed [ACC_W-1:0]    dth_shift;
    logic signed [ACC_W-1:0]    pos_x_wide;
    logic signed [ACC_W-1:0]    pos_y_wide;
    out_beat_t                  pose;

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign ang32    = HEAD_W'(heading_reg) << HEAD_SHIFT;

    podi_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .angle   (ang32),
        .done    (cordic_done),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    podi_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // Operand selection for the shared multiplier. The time products come
    // first, so the rotation only needs to multiply by cos and sin.
    always_comb begin
        el_ext = $signed({{(MUL_W - 16){1'b0}}, cmd_reg.elapsed});
        mul_a  = '0;
        mul_b  = '0;
        if (state_reg == ST_MULV) begin
            mul_b = el_ext;
            case (step_reg)
                3'd0:    mul_a = MUL_W'(held_vx_reg);
                3'd1:    mul_a = MUL_W'(held_vy_reg);
                3'd2:    mul_a = MUL_W'(held_wr_reg);
                default: mul_a = '0;
            endcase
        end else if (state_reg == ST_ROT) begin
            case (step_reg)
                3'd0: begin
                    mul_a = t_reg;
                    mul_b = MUL_W'(cos_q30);
                end
                3'd1: begin
                    mul_a = u_reg;
                    mul_b = MUL_W'(sin_q30);
                end
                3'd2: begin
                    mul_a = t_reg;
                    mul_b = MUL_W'(sin_q30);
                end
                3'd3: begin
                    mul_a = u_reg;
                    mul_b = MUL_W'(cos_q30);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    always_comb begin
        prod_acc    = $signed(prod[ACC_W-1:0]);
        prod_narrow = $signed(prod[MUL_W-1:0]);
        round_x     = accx_reg + ROUND_HALF;
        round_y     = accy_reg + ROUND_HALF;
        shift_x     = round_x >>> ROUND_SHIFT;
        shift_y     = round_y >>> ROUND_SHIFT;
        dth_wide    = ACC_W'(dth_reg);
        dth_shift   = (ANGLE_BITS >= DTH_FRAC) ? (dth_wide <<< DTH_SHL)
                                               : (dth_wide >>> DTH_SHR);
        pos_x_wide  = ACC_W'(pos_x_reg);
        pos_y_wide  = ACC_W'(pos_y_reg);
        pose.pose_x       = pos_x_wide[OUT_POS_W-1:0];
        pose.pose_y       = pos_y_wide[OUT_POS_W-1:0];
        pose.pose_heading = HEAD_W'(heading_reg) << HEAD_SHIFT;
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MULV;
                    step_next  = 3'd0;
                end
            end
            ST_MULV: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                if (cordic_done) begin
                    state_next = ST_ROT;
                    step_next  = 3'd0;
                end
            end
            ST_ROT: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            held_vx_reg <= '0;
            held_vy_reg <= '0;
            held_wr_reg <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_UPD) begin
                pos_x_reg   <= pos_x_reg + $signed(shift_x[POS_BITS-1:0]);
                pos_y_reg   <= pos_y_reg + $signed(shift_y[POS_BITS-1:0]);
                heading_reg <= heading_reg + dth_shift[ANGLE_BITS-1:0];
            end
            // The new command takes effect only for the following item.
            if (out_load) begin
                held_vx_reg <= cmd_reg.vel_x;
                held_vy_reg <= cmd_reg.vel_y;
                held_wr_reg <= cmd_reg.yaw_rate;
            end
        end
    end

    // The multiplier output is registered, so each capture
    // takes the product issued on the previous step.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_data;
        end
        if (state_reg == ST_MULV) begin
            case (step_reg)
                3'd1:    t_reg   <= prod_narrow;
                3'd2:    u_reg   <= prod_narrow;
                3'd3:    dth_reg <= prod_narrow;
                default: ;
            endcase
        end
        if (state_reg == ST_ROT) begin
            case (step_reg)
                3'd1:    accx_reg <= prod_acc;
                3'd2:    accx_reg <= accx_reg - prod_acc;
                3'd3:    accy_reg <= prod_acc;
                3'd4:    accy_reg <= accy_reg + prod_acc;
                default: ;
            endcase
        end
        if (out_load) begin
            m_data_reg <= pose;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/podi_checker.sv]
// ----------------------------------------------------------------------------
// Planar odometry integrator port checker
// Concurrent assertions on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module podi_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input podi_pkg::out_beat_t m_data
);

    // No result beat is pending right after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // One item at a time: an accepted beat closes the input until it is done.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A result never appears the cycle after an input beat is accepted.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result beat appeared too early");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

endmodule

bind planar_odometry_integrator_unit podi_checker u_podi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb_planar_odometry_integrator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives velocity commands through the input channel and checks every pose
// beat against a fixed pose or a cycle-free dead-reckoning predictor kept here.
// ----------------------------------------------------------------------------
module tb_planar_odometry_integrator_unit;
    import podi_pkg::*;

    localparam int    POS_W       = POS_BITS_DEF;
    localparam int    ANGLE_W     = ANGLE_BITS_DEF;
    localparam int    STAGES      = CORDIC_STAGES_DEF;
    localparam int    CYCLE_LIMIT = 6000000;
    localparam int    DRAIN_WAIT  = 60;
    localparam int    RANDOM_CMDS = 100;
    localparam int    FAST_RUN    = 16;
    localparam int    STEER_UNIT  = 65535 * 64;
    localparam logic signed [63:0] ROT_GAIN_Q30   = 64'sd652032874;
    localparam logic signed [63:0] ROUND_HALF_LSB = 64'sd536870912;

    typedef struct {
        in_beat_t    cmd;
        bit          known;
        logic [31:0] known_heading;
    } cmd_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    // Predicted block state.
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] world_y;
    logic [ANGLE_W-1:0]      heading_ang;
    logic signed [15:0]      cmd_vel_x;
    logic signed [15:0]      cmd_vel_y;
    logic signed [15:0]      cmd_yaw;

    logic [31:0] atan_steps [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    out_beat_t poses_due [$];
    cmd_row_t  directed_cmds [$];
    int        src_idle_by_phase [4]  = '{0, 82, 0, 31};
    int        sink_stall_by_phase [4] = '{0, 0, 82, 31};
    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    int        mismatches     = 0;
    int        cycle_count    = 0;

    planar_odometry_integrator_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Rotator for cos and sin in Q30. Angles in the left half of the circle
    // are turned by half a turn first and the results negated afterwards.
    function automatic void heading_cos_sin(input logic [31:0] ang,
                                            output logic signed [63:0] cos_q30,
                                            output logic signed [63:0] sin_q30);
        logic               flip;
        logic [31:0]        a;
        logic signed [63:0] x, y, z, nx, ny;
        a    = ang;
        flip = a[31] ^ a[30];
        if (flip) begin
            a[31] = ~a[31];
        end
        x = ROT_GAIN_Q30;
        y = 64'sd0;
        z = {{32{a[31]}}, a};
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (!z[63]) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - atan_steps[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + atan_steps[i];
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    // Integrates the held command over the elapsed time, latches the new
    // command and returns the pose that the block reports for it.
    function automatic out_beat_t integrate_pose(input in_beat_t cmd);
        logic signed [63:0] vx, vy, yaw, dt, c, s, rx, ry, dx, dy, dth;
        out_beat_t          pose;
        vx  = cmd_vel_x;
        vy  = cmd_vel_y;
        yaw = cmd_yaw;
        dt  = {48'd0, cmd.elapsed};
        heading_cos_sin(32'(heading_ang) << (32 - ANGLE_W), c, s);
        rx = vx * c - vy * s;
        ry = vx * s + vy * c;
        dx = (rx * dt + ROUND_HALF_LSB) >>> 30;
        dy = (ry * dt + ROUND_HALF_LSB) >>> 30;
        world_x = world_x + dx[POS_W-1:0];
        world_y = world_y + dy[POS_W-1:0];
        dth = yaw * dt;
        if (ANGLE_W >= 26) begin
            dth = dth <<< (ANGLE_W - 26);
        end else begin
            dth = dth >>> (26 - ANGLE_W);
        end
        heading_ang = heading_ang + dth[ANGLE_W-1:0];
        cmd_vel_x = cmd.vel_x;
        cmd_vel_y = cmd.vel_y;
        cmd_yaw   = cmd.yaw_rate;
        pose.pose_x       = world_x;
        pose.pose_y       = world_y;
        pose.pose_heading = 32'(heading_ang) << (32 - ANGLE_W);
        return pose;
    endfunction

    function automatic cmd_row_t cmd_row(input int vx, input int vy, input int yaw,
                                         input int dt, input bit known,
                                         input logic [31:0] hd);
        cmd_row_t row;
        row.cmd.vel_x    = 16'(vx);
        row.cmd.vel_y    = 16'(vy);
        row.cmd.yaw_rate = 16'(yaw);
        row.cmd.elapsed  = 16'(dt);
        row.known         = known;
        row.known_heading = hd;
        return row;
    endfunction

    function automatic logic [15:0] pick_field(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            2:       return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_beat_t random_cmd();
        in_beat_t cmd;
        cmd.vel_x    = pick_field(16'h8000, 16'h7FFF);
        cmd.vel_y    = pick_field(16'h8000, 16'h7FFF);
        cmd.yaw_rate = pick_field(16'h8000, 16'h7FFF);
        cmd.elapsed  = pick_field(16'h0000, 16'hFFFF);
        return cmd;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_command(input in_beat_t cmd, input bit known,
                                input out_beat_t known_pose);
        out_beat_t pose;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pose = integrate_pose(cmd);
        poses_due.push_back(known ? known_pose : pose);
        @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (poses_due.size() == 0) begin
                $error("pose beat with no command pending: x %0d y %0d heading %0h",
                       m_data.pose_x, m_data.pose_y, m_data.pose_heading);
                mismatches++;
            end else begin
                if (m_data.pose_x !== poses_due[0].pose_x) begin
                    $error("pose_x: expected %0d, got %0d",
                           poses_due[0].pose_x, m_data.pose_x);
                    mismatches++;
                end
                if (m_data.pose_y !== poses_due[0].pose_y) begin
                    $error("pose_y: expected %0d, got %0d",
                           poses_due[0].pose_y, m_data.pose_y);
                    mismatches++;
                end
                if (m_data.pose_heading !== poses_due[0].pose_heading) begin
                    $error("pose_heading: expected %0h, got %0h",
                           poses_due[0].pose_heading, m_data.pose_heading);
                    mismatches++;
                end
                void'(poses_due.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        out_beat_t               known_pose;
        in_beat_t                cmd;
        logic [31:0]             hdiff;
        int                      steer;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        world_x     = '0;
        world_y     = '0;
        heading_ang = '0;
        cmd_vel_x   = '0;
        cmd_vel_y   = '0;
        cmd_yaw     = '0;

        // Nothing is held after reset, so the first beats cannot move the pose.
        // Zero elapsed time latches a command without integrating anything.
        // The heading then walks through quarter turns, hitting both edges of
        // the rotator's half-turn fold, and wraps back to zero.
        directed_cmds.push_back(cmd_row(32767, -32768, 32767, 0, 1'b1, 32'h0000_0000));
        directed_cmds.push_back(cmd_row(0, 0, 16384, 0, 1'b1, 32'h0000_0000));
        directed_cmds.push_back(cmd_row(256, 0, 16384, 1024, 1'b1, 32'h4000_0000));
        directed_cmds.push_back(cmd_row(0, 256, 16384, 1024, 1'b0, '0));
        directed_cmds.push_back(cmd_row(-32768, -32768, 16384, 1024, 1'b0, '0));
        directed_cmds.push_back(cmd_row(32767, 32767, 16383, 1024, 1'b0, '0));
        // Largest turn rates over the longest interval, both signs.
        directed_cmds.push_back(cmd_row(-32768, 32767, -32768, 65535, 1'b0, '0));
        directed_cmds.push_back(cmd_row(32767, -32768, 32767, 65535, 1'b0, '0));
        directed_cmds.push_back(cmd_row(0, 0, -1, 65535, 1'b0, '0));
        directed_cmds.push_back(cmd_row(0, 0, 0, 1, 1'b0, '0));
        directed_cmds.push_back(cmd_row(1, -1, 1, 0, 1'b0, '0));
        directed_cmds.push_back(cmd_row(0, 0, 0, 65535, 1'b0, '0));
        directed_cmds.push_back(cmd_row(-1, 1, -1, 1, 1'b0, '0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cmds[i]) begin
            known_pose.pose_x       = '0;
            known_pose.pose_y       = '0;
            known_pose.pose_heading = directed_cmds[i].known_heading;
            send_command(directed_cmds[i].cmd, directed_cmds[i].known, known_pose);
        end

        // Steer the heading to about an eighth of a turn, then drive the
        // fastest diagonal for a while; at that heading it points along world x,
        // so pose_x takes its largest steps.
        hdiff = 32'h2000_0000 - (32'(heading_ang) << (32 - ANGLE_W));
        steer = $signed(hdiff) / STEER_UNIT;
        cmd.vel_x    = 16'sh7FFF;
        cmd.vel_y    = 16'sh8000;
        cmd.yaw_rate = 16'(steer);
        cmd.elapsed  = 16'd0;
        send_command(cmd, 1'b0, known_pose);
        cmd.yaw_rate = 16'sd0;
        cmd.elapsed  = 16'hFFFF;
        repeat (FAST_RUN) send_command(cmd, 1'b0, known_pose);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_idle_by_phase[p];
            sink_stall_pct = sink_stall_by_phase[p];
            repeat (RANDOM_CMDS) send_command(random_cmd(), 1'b0, known_pose);
        end

        s_valid <= 1'b0;
        while (poses_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
design/podi_pkg.sv
design/podi_cordic.sv
design/podi_mul.sv
design/planar_odometry_integrator_unit.sv
design/podi_checker.sv
tb/tb_planar_odometry_integrator_unit.sv
